@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

   // defaults for the top-level parameters
   localparam int DEF_SAMPLE_RATE = 48000;
   localparam int DEF_LINE_DEPTH  = 96000;

   // sample and arithmetic widths
   localparam int SAMPLE_W = 24;
   localparam int MUL_A_W  = SAMPLE_W + 1;   // tap, or tap minus filter state
   localparam int MUL_G_W  = 17;             // unsigned Q1.15 gain plus sign
   localparam int PROD_W   = MUL_A_W + MUL_G_W - 15;
   localparam int SUM_W    = PROD_W + 1;
   localparam int Q15_SHIFT = 15;
   localparam int ROUND_HALF = 16384;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_MS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_SYNC    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_LEVEL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO_INPUT    = 3'd6;

   // delay modes
   localparam logic [1:0] MODE_NORMAL    = 2'd0;
   localparam logic [1:0] MODE_PING_PONG = 2'd1;
   localparam logic [1:0] MODE_TAPE      = 2'd2;

   // register limits and reset values
   localparam logic [10:0] TIME_MIN      = 11'd1;
   localparam logic [10:0] TIME_MAX      = 11'd2000;
   localparam logic [10:0] TIME_RESET    = 11'd1;
   localparam logic [8:0]  BPM_MIN       = 9'd20;
   localparam logic [8:0]  BPM_MAX       = 9'd300;
   localparam logic [8:0]  BPM_RESET     = 9'd120;
   localparam logic [15:0] LEVEL_MAX     = 16'd32768;
   localparam logic [15:0] BYPASS_LEVEL  = 16'd33;
   localparam logic [14:0] FEEDBACK_MAX  = 15'd31129;
   localparam logic signed [MUL_G_W-1:0] TAPE_COEF = 17'sd9830;

   // delay length arithmetic
   localparam int MS_PER_SEC  = 1000;
   localparam int SEC_PER_MIN = 60;
   localparam int FRAC_N_W    = 9;
   localparam int FRAC_D_W    = 10;
   localparam int FRAC_N_MAX  = 333;
   localparam int DEN_W       = 19;   // 300 bpm times 1000

   localparam logic [10:0] BAND_QUARTER = 11'd200;
   localparam logic [10:0] BAND_THIRD   = 11'd500;
   localparam logic [10:0] BAND_HALF    = 11'd800;
   localparam logic [10:0] BAND_DOTTED  = 11'd1200;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic                       block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       clipped;
      logic                       last_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TAPE_MUL,
      ST_TAPE_ADD,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      STEP_FB_L,
      STEP_FB_R,
      STEP_LV_L,
      STEP_LV_R
   } step_type;

   typedef struct packed {
      logic [FRAC_N_W-1:0] n;
      logic [FRAC_D_W-1:0] d;
   } frac_type;

   typedef struct packed {
      logic                       clip;
      logic signed [SAMPLE_W-1:0] val;
   } sat_type;

   function automatic sat_type sat24(input logic signed [SUM_W-1:0] v);
      sat_type r;
      r.clip = 1'b0;
      r.val  = v[SAMPLE_W-1:0];
      if (v > 28'sd8388607) begin
         r.clip = 1'b1;
         r.val  = 24'sh7FFFFF;
      end else if (v < -28'sd8388608) begin
         r.clip = 1'b1;
         r.val  = 24'sh800000;
      end
      return r;
   endfunction

   // beat fraction n/d chosen by the time band
   function automatic frac_type beat_frac(input logic [10:0] t);
      frac_type f;
      priority if (t < BAND_QUARTER) begin
         f.n = 9'd1;   f.d = 10'd4;
      end else if (t < BAND_THIRD) begin
         f.n = 9'd333; f.d = 10'd1000;
      end else if (t < BAND_HALF) begin
         f.n = 9'd1;   f.d = 10'd2;
      end else if (t < BAND_DOTTED) begin
         f.n = 9'd3;   f.d = 10'd4;
      end else begin
         f.n = 9'd1;   f.d = 10'd1;
      end
      return f;
   endfunction

endpackage

@@ rtl/sfd_stream_if.sv @@
interface sfd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sfd_ram.sv @@
module sfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 96000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sfd_mul_q15.sv @@
// Shared multiplier: registered (a * g + half) >>> 15, i.e. rounded half up
// then floored.
module sfd_mul_q15 (
   input  logic                                clock,
   input  logic signed [sfd_pkg::MUL_A_W-1:0]  a,
   input  logic signed [sfd_pkg::MUL_G_W-1:0]  g,
   output logic signed [sfd_pkg::PROD_W-1:0]   q
);

   localparam int FULL_W = sfd_pkg::MUL_A_W + sfd_pkg::MUL_G_W;

   logic signed [FULL_W-1:0]          full;
   logic signed [sfd_pkg::PROD_W-1:0] q_ff;

   assign full = (FULL_W'(a) * FULL_W'(g)) + FULL_W'(sfd_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      q_ff <= full[FULL_W-1:sfd_pkg::Q15_SHIFT];
   end

   assign q = q_ff;

endmodule

@@ rtl/sfd_len_div.sv @@
// Restoring divider, one quotient bit per cycle. start wins over a run
// already in progress.
module sfd_len_div #(
   parameter int NUM_W = 31,
   parameter int DEN_W = sfd_pkg::DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;

   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign busy = run_ff | done_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/stereo_feedback_delay.sv @@
// Stereo feedback delay with normal, ping-pong and tape modes.
// req_if carries one stereo item (left_in, right_in, block_end, Q1.23);
// rsp_if returns one item per accepted item (left_out, right_out, clipped,
// last_out), in order. csr_* writes one register per cycle with csr_we high.
// One shared 25x17 multiplier forms the two feedback and two wet products
// (plus the tape lowpass product in tape mode), each product passing
// through a multiply state and an add/saturate state. An item runs from
// accept through fetch, the products and output load, and the block takes
// no new item until it is back in idle. A bypassed item (wet_level below
// 33) goes straight to output load and touches no state.
// Delay length is a serial divide, run after reset and after each register
// write; req_if.ready stays low meanwhile.
// Reset: registers take their defaults, write pointer and tape filter clear.
// The delay lines are not swept: entries not yet written since reset read as
// zero, tracked by the write pointer and a wrapped flag.
// A stalled rsp_if holds its item; the block can accept and process the next
// item meanwhile and waits only at output load for the slot to free up.
module stereo_feedback_delay #(
   parameter int SAMPLE_RATE = sfd_pkg::DEF_SAMPLE_RATE,
   parameter int LINE_DEPTH  = sfd_pkg::DEF_LINE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   sfd_stream_if.sink                       req_if,
   sfd_stream_if.source                     rsp_if,
   input  logic                             csr_we,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam longint NUM_MAX =
      longint'(sfd_pkg::SEC_PER_MIN) * SAMPLE_RATE * sfd_pkg::FRAC_N_MAX +
      longint'(sfd_pkg::TIME_MAX) * SAMPLE_RATE;
   localparam int NUM_W = $clog2(NUM_MAX + 1);
   localparam int DEN_W = sfd_pkg::DEN_W;
   localparam int SW    = sfd_pkg::SAMPLE_W;
   // signed widening to the multiplier's a-input width
   localparam int MUL_A_W_T = sfd_pkg::MUL_A_W;

   localparam logic [NUM_W-1:0]  RATE_K    = NUM_W'(SAMPLE_RATE);
   localparam logic [NUM_W-1:0]  SYNC_BASE = NUM_W'(sfd_pkg::SEC_PER_MIN * SAMPLE_RATE);
   localparam logic [NUM_W-1:0]  LEN_MAX_Q = NUM_W'(LINE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] LEN_MAX   = ADDR_W'(LINE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] WP_LAST   = ADDR_W'(LINE_DEPTH - 1);
   localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(LINE_DEPTH);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [1:0]  delay_mode_ff;
   logic [10:0] time_ms_ff;
   logic        tempo_sync_ff;
   logic [8:0]  tempo_bpm_ff;
   logic [15:0] wet_level_ff;
   logic [14:0] feedback_gain_ff;
   logic        mono_input_ff;
   logic        len_pend_ff;     // delay length needs recomputing
   logic        csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_mode_ff    <= sfd_pkg::MODE_NORMAL;
         time_ms_ff       <= sfd_pkg::TIME_RESET;
         tempo_sync_ff    <= 1'b0;
         tempo_bpm_ff     <= sfd_pkg::BPM_RESET;
         wet_level_ff     <= '0;
         feedback_gain_ff <= '0;
         mono_input_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfd_pkg::CSR_DELAY_MODE:    delay_mode_ff    <= csr_wdata[1:0];
            sfd_pkg::CSR_TIME_MS:       time_ms_ff       <= csr_wdata[10:0];
            sfd_pkg::CSR_TEMPO_SYNC:    tempo_sync_ff    <= csr_wdata[0];
            sfd_pkg::CSR_TEMPO_BPM:     tempo_bpm_ff     <= csr_wdata[8:0];
            sfd_pkg::CSR_WET_LEVEL:     wet_level_ff     <= csr_wdata;
            sfd_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[14:0];
            sfd_pkg::CSR_MONO_INPUT:    mono_input_ff    <= csr_wdata[0];
            default: ;   // unknown index, ignored
         endcase
      end
   end

   // any write to a real register recomputes the length (index 7 is not one)
   assign csr_hit = csr_we && (csr_index <= sfd_pkg::CSR_MONO_INPUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_pend_ff <= 1'b1;
      end else begin
         len_pend_ff <= csr_hit;
      end
   end

   // clamped register views
   logic [10:0] time_c;
   logic [8:0]  bpm_c;
   logic [15:0] level_c;
   logic [14:0] fb_c;
   logic        bypass;
   logic        tape_mode;
   logic        ping_mode;

   always_comb begin
      time_c  = (time_ms_ff < sfd_pkg::TIME_MIN) ? sfd_pkg::TIME_MIN :
                (time_ms_ff > sfd_pkg::TIME_MAX) ? sfd_pkg::TIME_MAX : time_ms_ff;
      bpm_c   = (tempo_bpm_ff < sfd_pkg::BPM_MIN) ? sfd_pkg::BPM_MIN :
                (tempo_bpm_ff > sfd_pkg::BPM_MAX) ? sfd_pkg::BPM_MAX : tempo_bpm_ff;
      level_c = (wet_level_ff > sfd_pkg::LEVEL_MAX) ? sfd_pkg::LEVEL_MAX : wet_level_ff;
      fb_c    = (feedback_gain_ff > sfd_pkg::FEEDBACK_MAX) ?
                sfd_pkg::FEEDBACK_MAX : feedback_gain_ff;
   end

   assign bypass    = level_c < sfd_pkg::BYPASS_LEVEL;
   assign tape_mode = delay_mode_ff == sfd_pkg::MODE_TAPE;
   assign ping_mode = delay_mode_ff == sfd_pkg::MODE_PING_PONG;

   // ---------------------------------------------------------------
   // Delay length: samples = num / den, computed serially
   //   free:   time_ms * rate / 1000
   //   synced: 60 * rate * n / (bpm * d)
   // ---------------------------------------------------------------
   sfd_pkg::frac_type frac;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic              div_busy;
   logic              div_done;
   logic [NUM_W-1:0]  div_quo;
   logic [ADDR_W-1:0] len_ff;

   always_comb begin
      frac = sfd_pkg::beat_frac(time_c);
      if (tempo_sync_ff) begin
         div_num = SYNC_BASE * NUM_W'(frac.n);
         div_den = DEN_W'(bpm_c) * DEN_W'(frac.d);
      end else begin
         div_num = RATE_K * NUM_W'(time_c);
         div_den = DEN_W'(sfd_pkg::MS_PER_SEC);
      end
   end

   sfd_len_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_len_div (
      .clock (clock),
      .reset (reset),
      .start (len_pend_ff),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   // clamp to 1 .. LINE_DEPTH-1
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= ADDR_W'(1);
      end else if (div_done) begin
         if (div_quo == '0) begin
            len_ff <= ADDR_W'(1);
         end else if (div_quo > LEN_MAX_Q) begin
            len_ff <= LEN_MAX;
         end else begin
            len_ff <= div_quo[ADDR_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   sfd_pkg::state_type state_ff, state_in;
   sfd_pkg::step_type  step_ff, step_in;

   logic req_accept;
   logic rsp_load;
   logic ram_we;
   logic slot_free;

   logic rsp_valid_ff;
   sfd_pkg::rsp_payload_type rsp_data_ff;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == sfd_pkg::ST_IDLE) && !len_pend_ff && !div_busy;
   assign req_accept   = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfd_pkg::ST_IDLE;
         step_ff  <= sfd_pkg::STEP_FB_L;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // item registers
   logic bypass_ff;
   logic last_ff;
   logic signed [SW-1:0] xl_ff, xr_ff;
   logic signed [SW-1:0] tap_l_ff, tap_r_ff;
   logic signed [SW-1:0] wl_ff, wr_ff, ol_ff, or_ff;
   logic                 clip_ff;
   logic                 rd_valid_ff;

   // persistent state
   logic [ADDR_W-1:0]    wp_ff;
   logic                 wrapped_ff;   // every line entry written at least once
   logic signed [SW-1:0] tape_ff;

   // shared multiplier operands
   logic signed [sfd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [sfd_pkg::MUL_G_W-1:0] mul_g;
   logic signed [sfd_pkg::PROD_W-1:0]  mul_q;
   logic signed [sfd_pkg::MUL_G_W-1:0] g_fb, g_lv;

   assign g_fb = $signed({2'b00, fb_c});
   assign g_lv = $signed({1'b0, level_c});

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rsp_load = 1'b0;
      ram_we   = 1'b0;
      mul_a    = '0;
      mul_g    = '0;
      unique case (state_ff)
         sfd_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = bypass ? sfd_pkg::ST_OUT : sfd_pkg::ST_FETCH;
            end
         end
         sfd_pkg::ST_FETCH: begin
            step_in  = sfd_pkg::STEP_FB_L;
            state_in = tape_mode ? sfd_pkg::ST_TAPE_MUL : sfd_pkg::ST_MUL;
         end
         sfd_pkg::ST_TAPE_MUL: begin
            mul_a    = MUL_A_W_T'(tap_l_ff) - MUL_A_W_T'(tape_ff);
            mul_g    = sfd_pkg::TAPE_COEF;
            state_in = sfd_pkg::ST_TAPE_ADD;
         end
         sfd_pkg::ST_TAPE_ADD: begin
            state_in = sfd_pkg::ST_MUL;
         end
         sfd_pkg::ST_MUL: begin
            unique case (step_ff)
               sfd_pkg::STEP_FB_L: begin
                  mul_a = MUL_A_W_T'(ping_mode ? tap_r_ff : tap_l_ff);
                  mul_g = g_fb;
               end
               sfd_pkg::STEP_FB_R: begin
                  mul_a = MUL_A_W_T'(ping_mode ? tap_l_ff : tap_r_ff);
                  mul_g = g_fb;
               end
               sfd_pkg::STEP_LV_L: begin
                  mul_a = MUL_A_W_T'(tap_l_ff);
                  mul_g = g_lv;
               end
               sfd_pkg::STEP_LV_R: begin
                  mul_a = MUL_A_W_T'(tap_r_ff);
                  mul_g = g_lv;
               end
            endcase
            state_in = sfd_pkg::ST_ADD;
         end
         sfd_pkg::ST_ADD: begin
            unique case (step_ff)
               sfd_pkg::STEP_FB_L: step_in = sfd_pkg::STEP_FB_R;
               sfd_pkg::STEP_FB_R: step_in = sfd_pkg::STEP_LV_L;
               sfd_pkg::STEP_LV_L: step_in = sfd_pkg::STEP_LV_R;
               sfd_pkg::STEP_LV_R: step_in = sfd_pkg::STEP_FB_L;
            endcase
            state_in = (step_ff == sfd_pkg::STEP_LV_R) ? sfd_pkg::ST_OUT : sfd_pkg::ST_MUL;
         end
         sfd_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               ram_we   = !bypass_ff;
               state_in = sfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfd_pkg::ST_IDLE;
         end
      endcase
   end

   sfd_mul_q15 u_mul (
      .clock (clock),
      .a     (mul_a),
      .g     (mul_g),
      .q     (mul_q)
   );

   // ---------------------------------------------------------------
   // Delay lines
   // ---------------------------------------------------------------
   logic [ADDR_W:0]   rp_diff;
   logic [ADDR_W-1:0] rp;
   logic [SW-1:0]     rd_l, rd_r;

   assign rp_diff = {1'b0, wp_ff} - {1'b0, len_ff};
   assign rp = rp_diff[ADDR_W] ? ADDR_W'(rp_diff + DEPTH_X) : rp_diff[ADDR_W-1:0];

   sfd_ram #(
      .WIDTH (SW),
      .DEPTH (LINE_DEPTH)
   ) u_left_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (wl_ff),
      .rd_en   (req_accept),
      .rd_addr (rp),
      .rd_data (rd_l)
   );

   sfd_ram #(
      .WIDTH (SW),
      .DEPTH (LINE_DEPTH)
   ) u_right_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (wr_ff),
      .rd_en   (req_accept),
      .rd_addr (rp),
      .rd_data (rd_r)
   );

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   logic signed [sfd_pkg::SUM_W-1:0] add_base;
   logic signed [sfd_pkg::SUM_W-1:0] add_sum;
   sfd_pkg::sat_type                 add_sat;
   logic                             step_left;

   assign step_left = (step_ff == sfd_pkg::STEP_FB_L) || (step_ff == sfd_pkg::STEP_LV_L);

   always_comb begin
      if (state_ff == sfd_pkg::ST_TAPE_ADD) begin
         add_base = sfd_pkg::SUM_W'(tape_ff);
      end else begin
         add_base = sfd_pkg::SUM_W'(step_left ? xl_ff : xr_ff);
      end
      add_sum = add_base + sfd_pkg::SUM_W'(mul_q);
      add_sat = sfd_pkg::sat24(add_sum);
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         xl_ff     <= req_if.data.left_in;
         xr_ff     <= mono_input_ff ? req_if.data.left_in : req_if.data.right_in;
         last_ff   <= req_if.data.block_end;
         bypass_ff <= bypass;
         // bypass result; overwritten when the item is processed
         ol_ff     <= req_if.data.left_in;
         or_ff     <= mono_input_ff ? req_if.data.left_in : req_if.data.right_in;
         clip_ff   <= 1'b0;
         rd_valid_ff <= wrapped_ff || (rp < wp_ff);
      end else begin
         unique case (state_ff)
            sfd_pkg::ST_FETCH: begin
               // never-written entries read as zero
               tap_l_ff <= rd_valid_ff ? $signed(rd_l) : '0;
               tap_r_ff <= rd_valid_ff ? $signed(rd_r) : '0;
            end
            sfd_pkg::ST_TAPE_ADD: begin
               tap_l_ff <= add_sat.val;
               tap_r_ff <= add_sat.val;
               clip_ff  <= clip_ff | add_sat.clip;
            end
            sfd_pkg::ST_ADD: begin
               clip_ff <= clip_ff | add_sat.clip;
               unique case (step_ff)
                  sfd_pkg::STEP_FB_L: wl_ff <= add_sat.val;
                  sfd_pkg::STEP_FB_R: wr_ff <= add_sat.val;
                  sfd_pkg::STEP_LV_L: ol_ff <= add_sat.val;
                  sfd_pkg::STEP_LV_R: or_ff <= add_sat.val;
               endcase
            end
            default: ;
         endcase
      end
   end

   // tape filter, write pointer and wrap flag
   always_ff @(posedge clock) begin
      if (reset) begin
         tape_ff    <= '0;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (state_ff == sfd_pkg::ST_TAPE_ADD) begin
            tape_ff <= add_sat.val;
         end
         if (ram_we) begin
            if (wp_ff == WP_LAST) begin
               wp_ff      <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               wp_ff <= wp_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.left_out  <= ol_ff;
         rsp_data_ff.right_out <= mono_input_ff ? ol_ff : or_ff;
         rsp_data_ff.clipped   <= clip_ff;
         rsp_data_ff.last_out  <= last_ff;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_if.ready)
      else $error("item accepted while previous one in flight");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) && (len_ff <= LEN_MAX))
      else $error("delay length out of range");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> ((($past(wp_ff) == WP_LAST) && (wp_ff == '0)) ||
                  (($past(wp_ff) != WP_LAST) && (wp_ff == $past(wp_ff) + 1'b1))))
      else $error("write pointer did not advance by one");

   a_len_block: assert property (@(posedge clock) disable iff (reset)
      (len_pend_ff || div_busy) |-> !req_if.ready)
      else $error("item accepted while delay length is stale");
`endif

endmodule

@@ bench/stereo_delay_checker.sv @@
`timescale 1ns / 1ps

// Watches the stream and config ports, predicts each output item and
// compares it with what the block returns.
module stereo_delay_checker
   import sfd_pkg::*;
#(
   parameter int SAMPLE_RATE = DEF_SAMPLE_RATE,
   parameter int LINE_DEPTH  = DEF_LINE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam longint SAMPLE_MAX = 64'sd8388607;
   localparam longint SAMPLE_MIN = -64'sd8388608;

   logic signed [SAMPLE_W-1:0] left_line  [LINE_DEPTH];
   logic signed [SAMPLE_W-1:0] right_line [LINE_DEPTH];
   logic signed [SAMPLE_W-1:0] tape_state;
   int                         wr_ptr;
   int                         delay_len;

   logic [1:0]  reg_mode;
   logic [10:0] reg_time;
   logic        reg_sync;
   logic [8:0]  reg_bpm;
   logic [15:0] reg_level;
   logic [14:0] reg_fb;
   logic        reg_mono;

   rsp_payload_type expected_mix_q [$];
   rsp_payload_type want;

   // tap * gain, round half up, floor divide by 2^15
   function automatic longint q15_mul(longint a, longint g);
      return (a * g + ROUND_HALF) >>> Q15_SHIFT;
   endfunction

   // {clip, value}
   function automatic logic [SAMPLE_W:0] saturate(longint v);
      if (v > SAMPLE_MAX) return {1'b1, 24'h7FFFFF};
      if (v < SAMPLE_MIN) return {1'b1, 24'h800000};
      return {1'b0, v[SAMPLE_W-1:0]};
   endfunction

   function automatic int calc_delay();
      longint t, bpm, n, d, s;
      t = (reg_time < TIME_MIN) ? TIME_MIN : (reg_time > TIME_MAX) ? TIME_MAX : reg_time;
      if (reg_sync) begin
         bpm = (reg_bpm < BPM_MIN) ? BPM_MIN : (reg_bpm > BPM_MAX) ? BPM_MAX : reg_bpm;
         if (t < BAND_QUARTER) begin
            n = 1;   d = 4;
         end else if (t < BAND_THIRD) begin
            n = 333; d = 1000;
         end else if (t < BAND_HALF) begin
            n = 1;   d = 2;
         end else if (t < BAND_DOTTED) begin
            n = 3;   d = 4;
         end else begin
            n = 1;   d = 1;
         end
         s = (longint'(SEC_PER_MIN) * SAMPLE_RATE * n) / (bpm * d);
      end else begin
         s = (t * SAMPLE_RATE) / MS_PER_SEC;
      end
      if (s < 1) s = 1;
      if (s > LINE_DEPTH - 1) s = LINE_DEPTH - 1;
      return int'(s);
   endfunction

   function automatic void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_DELAY_MODE:    reg_mode  = v[1:0];
         CSR_TIME_MS:       reg_time  = v[10:0];
         CSR_TEMPO_SYNC:    reg_sync  = v[0];
         CSR_TEMPO_BPM:     reg_bpm   = v[8:0];
         CSR_WET_LEVEL:     reg_level = v[15:0];
         CSR_FEEDBACK_GAIN: reg_fb    = v[14:0];
         CSR_MONO_INPUT:    reg_mono  = v[0];
         default: ;
      endcase
      delay_len = calc_delay();
   endfunction

   // one stereo item through the delay; updates lines, pointer, tape filter
   function automatic rsp_payload_type mix_sample(req_payload_type x);
      rsp_payload_type   y;
      longint            xl, xr, lvl, fbg, tl, tr, fil;
      logic [SAMPLE_W:0] s, sl, sr;
      logic              clip;
      int                rp;
      xl   = longint'($signed(x.left_in));
      xr   = reg_mono ? xl : longint'($signed(x.right_in));
      lvl  = (reg_level > LEVEL_MAX) ? LEVEL_MAX : reg_level;
      fbg  = (reg_fb > FEEDBACK_MAX) ? FEEDBACK_MAX : reg_fb;
      clip = 1'b0;
      y.last_out = x.block_end;
      if (lvl < BYPASS_LEVEL) begin
         y.left_out  = xl[SAMPLE_W-1:0];
         y.right_out = xr[SAMPLE_W-1:0];
      end else begin
         rp = wr_ptr - delay_len;
         if (rp < 0) rp += LINE_DEPTH;
         tl = left_line[rp];
         tr = right_line[rp];
         if (reg_mode == MODE_TAPE) begin
            fil = tape_state;
            s = saturate(fil + q15_mul(tl - fil, TAPE_COEF));
            clip |= s[SAMPLE_W];
            tape_state = s[SAMPLE_W-1:0];
            tl = tape_state;
            tr = tape_state;
         end
         if (reg_mode == MODE_PING_PONG) begin
            sl = saturate(xl + q15_mul(tr, fbg));
            sr = saturate(xr + q15_mul(tl, fbg));
         end else begin
            sl = saturate(xl + q15_mul(tl, fbg));
            sr = saturate(xr + q15_mul(tr, fbg));
         end
         clip |= sl[SAMPLE_W] | sr[SAMPLE_W];
         left_line[wr_ptr]  = sl[SAMPLE_W-1:0];
         right_line[wr_ptr] = sr[SAMPLE_W-1:0];
         sl = saturate(xl + q15_mul(tl, lvl));
         sr = saturate(xr + q15_mul(tr, lvl));
         clip |= sl[SAMPLE_W] | sr[SAMPLE_W];
         y.left_out  = sl[SAMPLE_W-1:0];
         y.right_out = reg_mono ? sl[SAMPLE_W-1:0] : sr[SAMPLE_W-1:0];
         wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      end
      y.clipped = clip;
      return y;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++) begin
            left_line[i]  = '0;
            right_line[i] = '0;
         end
         wr_ptr     = 0;
         tape_state = '0;
         reg_mode   = MODE_NORMAL;
         reg_time   = TIME_RESET;
         reg_sync   = 1'b0;
         reg_bpm    = BPM_RESET;
         reg_level  = '0;
         reg_fb     = '0;
         reg_mono   = 1'b0;
         delay_len  = calc_delay();
         expected_mix_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) write_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) expected_mix_q.push_back(mix_sample(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_mix_q.size() == 0) begin
               $error("output item with no input item outstanding");
               fail_count++;
            end else begin
               want = expected_mix_q.pop_front();
               if (rsp_data.left_out !== want.left_out) begin
                  $error("left_out: expected %0d, got %0d",
                         $signed(want.left_out), $signed(rsp_data.left_out));
                  fail_count++;
               end
               if (rsp_data.right_out !== want.right_out) begin
                  $error("right_out: expected %0d, got %0d",
                         $signed(want.right_out), $signed(rsp_data.right_out));
                  fail_count++;
               end
               if (rsp_data.clipped !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_data.clipped);
                  fail_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_mix_q.size();
   end

endmodule

@@ bench/tb_stereo_feedback_delay.sv @@
`timescale 1ns / 1ps

// Top of the delay bench: clock, reset, stimulus and the verdict.
// All checking lives in stereo_delay_checker.
module tb_stereo_feedback_delay;
   import sfd_pkg::*;

   // index 7 has no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [SAMPLE_W-1:0]  S_MAX     = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0]  S_MIN     = 24'h800000;
   localparam int TOTAL_ITEMS = 1050;
   localparam int IDLE_SETTLE = 20;   // cycles after the last output before a csr write
   localparam int END_SETTLE  = 40;   // watch for stray outputs at the end

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    items_sent;
   int                    stall_pct;

   sfd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   sfd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   stereo_feedback_delay u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stereo_delay_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_data      (req_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_ch.data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // mostly short idles, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int stall_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // full scale, rails and small values around zero
   function automatic logic [SAMPLE_W-1:0] rand_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2, 3:    return {{12{r[11]}}, r[11:0]};
         default: return r[SAMPLE_W-1:0];
      endcase
   endfunction

   // all csr inputs change on the falling edge; the write lands on the next rise
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
   endtask

   // back-to-back writes of every register, sometimes a dead write to the
   // spare index, then release the write enable
   task automatic set_regs(logic [15:0] mode, logic [15:0] t_ms, logic [15:0] sync,
                           logic [15:0] bpm, logic [15:0] level, logic [15:0] fb,
                           logic [15:0] mono);
      write_reg(CSR_DELAY_MODE, mode);
      write_reg(CSR_TIME_MS, t_ms);
      write_reg(CSR_TEMPO_SYNC, sync);
      write_reg(CSR_TEMPO_BPM, bpm);
      write_reg(CSR_WET_LEVEL, level);
      write_reg(CSR_FEEDBACK_GAIN, fb);
      write_reg(CSR_MONO_INPUT, mono);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, 16'($urandom()));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop sending and wait until every predicted output has come back,
   // then give the block time to go fully idle
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // valid stays high between back-to-back items; one assignment per edge
   task automatic send_item(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic last);
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data  <= '{left_in: l, right_in: r, block_end: last};
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      items_sent++;
   endtask

   // random settings, weighted toward short delays so the feedback path
   // actually reads back written samples; extremes and out-of-range values
   // (which the block clamps or masks) show up regularly
   task automatic shuffle_regs();
      logic [15:0] m, t, sy, b, lv, fb, mo;
      m  = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
         0:       t = 16'd0;
         1:       t = 16'd2047;
         2:       t = 16'd2000;
         3:       t = 16'($urandom());
         4:       t = 16'($urandom_range(1, 2047));
         default: t = 16'($urandom_range(1, 3));
      endcase
      sy = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'd0;
      // synced: spread time over every beat-division band
      if (sy[0]) t = 16'($urandom_range(0, 2047));
      case ($urandom_range(0, 7))
         0:       b = 16'd0;
         1:       b = 16'd20;
         2:       b = 16'd300;
         3:       b = 16'd511;
         4:       b = 16'($urandom());
         default: b = 16'($urandom_range(20, 300));
      endcase
      case ($urandom_range(0, 11))
         0:       lv = 16'd0;
         1:       lv = 16'd32;
         2:       lv = 16'd33;
         3:       lv = 16'd32768;
         4:       lv = 16'hFFFF;
         5:       lv = 16'($urandom());
         default: lv = 16'($urandom_range(8192, 32768));
      endcase
      case ($urandom_range(0, 7))
         0:       fb = 16'd0;
         1:       fb = 16'd31129;
         2:       fb = 16'd32767;
         3:       fb = 16'($urandom());
         default: fb = 16'($urandom_range(0, 31129));
      endcase
      mo = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3) == 0);
      set_regs(m, t, sy, b, lv, fb, mo);
   endtask

   // output-side backpressure: stall density changes from one random stretch
   // to the next, including stretches with no stalls at all
   initial begin
      int stall_left;
      int stretch_left;
      stall_left   = 0;
      stretch_left = 0;
      stall_pct    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(100, 400);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 30;
               default: stall_pct = 60;
            endcase
         end
         stretch_left--;
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = stall_len();
         end
      end
   end

   initial begin
      int  n_phase;
      bit  gaps_on;
      items_sent = 0;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: wet level 0, so every item is a straight bypass
      send_item(S_MAX, S_MIN, 1'b1);
      send_item(S_MIN, S_MAX, 1'b0);
      send_item(24'd0, 24'hFFFFFF, 1'b1);

      // level one below the bypass threshold, mono: right echoes left
      drain();
      set_regs(MODE_NORMAL, 16'd1, 16'd0, 16'd120, 16'd32, 16'd0, 16'd1);
      send_item(S_MAX, 24'd0, 1'b0);
      send_item(S_MIN, 24'd5, 1'b1);

      // level exactly at the threshold, full feedback, normal mode
      drain();
      set_regs(MODE_NORMAL, 16'd1, 16'd0, 16'd120, 16'd33, 16'd31129, 16'd0);
      send_item(S_MAX, S_MIN, 1'b1);
      send_item(S_MIN, S_MAX, 1'b0);
      send_item(24'd1, 24'hFFFFFF, 1'b1);

      // ping-pong, time below range (clamps to 1 ms), full wet, mono
      drain();
      set_regs(MODE_PING_PONG, 16'd0, 16'd0, 16'd120, 16'd32768, 16'd31129, 16'd1);
      send_item(S_MAX, S_MIN, 1'b0);
      send_item(S_MIN, S_MAX, 1'b1);
      send_item(24'h000100, 24'hFFFF00, 1'b0);

      // tape, time and gains above range
      drain();
      set_regs(MODE_TAPE, 16'd2047, 16'd0, 16'd120, 16'hFFFF, 16'd32767, 16'd0);
      send_item(S_MAX, S_MAX, 1'b1);
      send_item(S_MIN, S_MIN, 1'b0);
      send_item(24'd0, 24'd0, 1'b1);

      // unused mode value acts as normal; synced at out-of-range tempo
      drain();
      set_regs(16'd3, 16'd2000, 16'd1, 16'd511, 16'd32768, 16'd0, 16'd0);
      send_item(S_MAX, S_MIN, 1'b0);
      send_item(S_MIN, S_MAX, 1'b1);
      send_item(24'h123456, 24'hEDCBA9, 1'b0);

      // synced, quarter-note band, tempo below range
      drain();
      set_regs(MODE_NORMAL, 16'd199, 16'd1, 16'd0, 16'd16384, 16'd16384, 16'd0);
      send_item(S_MAX, S_MIN, 1'b1);
      send_item(S_MIN, S_MAX, 1'b0);

      // random phases: new settings while idle, then a burst of items;
      // sometimes the sender holds off mid-phase until everything is back
      while (items_sent < TOTAL_ITEMS) begin
         drain();
         shuffle_regs();
         gaps_on = ($urandom_range(0, 3) != 0);
         n_phase = $urandom_range(40, 140);
         for (int k = 0; k < n_phase; k++) begin
            if (gaps_on) idle_for(gap_len());
            if (k == n_phase / 2 && $urandom_range(0, 2) == 0) drain();
            send_item(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
         end
      end

      drain();
      repeat (END_SETTLE) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/sfd_pkg.sv
rtl/sfd_stream_if.sv
rtl/sfd_ram.sv
rtl/sfd_mul_q15.sv
rtl/sfd_len_div.sv
rtl/stereo_feedback_delay.sv
bench/stereo_delay_checker.sv
bench/tb_stereo_feedback_delay.sv
